### rtl/dlr_pkg.sv
// Shared types and defaults for the DDA line rasterizer.
// No dependencies; used by the top level and dlr_ctrl.
`timescale 1ns / 1ps
`default_nettype none

package dlr_pkg;

    localparam int DLR_COORD_BITS = 12;
    localparam int DLR_FRAC_BITS  = 16;

    // request opcodes
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV_X,
        ST_DIV_Y
    } dlr_state_t;

    // sequencer commands to the datapath
    typedef struct packed {
        logic busy;
        logic div_start;
        logic div_sel_y;
        logic load_inc_x;
        logic load_inc_y;
        logic push_start;
    } dlr_ctrl_t;

endpackage

`default_nettype wire

### rtl/dda_line_rasterizer_unit.sv
// DDA line rasterizer top level: request decode, accumulators, output register.
// Depends on dlr_pkg, dlr_ctrl and dlr_divider.
`timescale 1ns / 1ps
`default_nettype none

// DDA line rasterizer. A start request (opcode 0) takes two endpoints, sets the
// step count to max(|dx|, |dy|) and computes per-axis increments delta/steps in
// signed fixed point (FRAC_BITS fraction bits, truncated toward zero), then
// places the accumulators on the start point. Each step request (opcode 1)
// returns one pixel (accumulators truncated toward zero) and advances the
// accumulators; exactly 'steps' pixels come out, the endpoint is not drawn and a
// zero-length line draws nothing. last_pixel marks the final pixel of a line.
// Every request returns exactly one result: a start, or a step with no line in
// progress, returns pixel_valid 0 with zero coordinates. A new start abandons
// the current line.
// Timing: a step request is answered from the output register, so pixels stream
// at one per clock while the consumer keeps out_ready high. A start request with
// a nonzero length holds in_ready low while both increments come from a single
// serial restoring divider that produces one quotient bit per cycle, first for x
// and then for y. A zero-length start skips the divider and answers in the next
// cycle. The result sits in an output register, so with the sequencer idle a new
// request is taken in the same cycle the previous result is drained.
module dda_line_rasterizer_unit #(
    parameter int COORD_BITS = dlr_pkg::DLR_COORD_BITS,
    parameter int FRAC_BITS  = dlr_pkg::DLR_FRAC_BITS
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // request channel
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic                         opcode,
    input  wire logic signed [COORD_BITS-1:0] x_start,
    input  wire logic signed [COORD_BITS-1:0] y_start,
    input  wire logic signed [COORD_BITS-1:0] x_end,
    input  wire logic signed [COORD_BITS-1:0] y_end,
    // result channel
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic                              pixel_valid,
    output logic signed      [COORD_BITS-1:0] pixel_x,
    output logic signed      [COORD_BITS-1:0] pixel_y,
    output logic                              last_pixel
);

    localparam int ACC_W = COORD_BITS + FRAC_BITS;
    localparam int INC_W = FRAC_BITS + 2;

    dlr_pkg::dlr_ctrl_t ctrl;

    // ---------------------------------------------------------------
    // Request decode and line set-up arithmetic
    // ---------------------------------------------------------------
    logic                  accept;
    logic                  accept_start;
    logic                  accept_step;
    logic signed [COORD_BITS:0] dx;
    logic signed [COORD_BITS:0] dy;
    logic [COORD_BITS:0]   dx_abs;
    logic [COORD_BITS:0]   dy_abs;
    logic [COORD_BITS-1:0] mag_x;
    logic [COORD_BITS-1:0] mag_y;
    logic [COORD_BITS-1:0] steps;
    logic                  steps_zero;

    assign accept       = in_valid && in_ready;
    assign accept_start = accept && (opcode == dlr_pkg::OP_START);
    assign accept_step  = accept && (opcode == dlr_pkg::OP_STEP);

    // deltas need one extra bit; their magnitudes fit back into COORD_BITS
    assign dx     = {x_end[COORD_BITS-1], x_end} - {x_start[COORD_BITS-1], x_start};
    assign dy     = {y_end[COORD_BITS-1], y_end} - {y_start[COORD_BITS-1], y_start};
    assign dx_abs = dx[COORD_BITS] ? -dx : dx;
    assign dy_abs = dy[COORD_BITS] ? -dy : dy;
    assign mag_x  = dx_abs[COORD_BITS-1:0];
    assign mag_y  = dy_abs[COORD_BITS-1:0];
    assign steps  = (mag_x >= mag_y) ? mag_x : mag_y;
    assign steps_zero = (steps == '0);

    // ---------------------------------------------------------------
    // Line state
    // ---------------------------------------------------------------
    logic signed [ACC_W-1:0] x_accum_reg,     x_accum_next;
    logic signed [ACC_W-1:0] y_accum_reg,     y_accum_next;
    logic signed [INC_W-1:0] x_inc_reg,       x_inc_next;
    logic signed [INC_W-1:0] y_inc_reg,       y_inc_next;
    logic [COORD_BITS-1:0]   pixels_left_reg, pixels_left_next;
    logic [COORD_BITS-1:0]   mag_y_reg,       mag_y_next;
    logic                    x_neg_reg,       x_neg_next;
    logic                    y_neg_reg,       y_neg_next;

    // ---------------------------------------------------------------
    // Shared divider and its sequencer
    // ---------------------------------------------------------------
    logic [COORD_BITS-1:0] div_dividend;
    logic [COORD_BITS-1:0] div_divisor;
    logic [FRAC_BITS:0]    div_quotient;
    logic                  div_done;
    logic signed [INC_W-1:0] quot_pos;
    logic signed [INC_W-1:0] quot_neg;

    // x is divided straight off the request; y from the latched copy
    assign div_dividend = ctrl.div_sel_y ? mag_y_reg : mag_x;
    assign div_divisor  = ctrl.div_sel_y ? pixels_left_reg : steps;

    dlr_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start_line (accept_start && !steps_zero),
        .div_done   (div_done),
        .ctrl       (ctrl)
    );

    dlr_divider #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctrl.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .done     (div_done)
    );

    assign quot_pos = {1'b0, div_quotient};
    assign quot_neg = -quot_pos;

    // ---------------------------------------------------------------
    // Pixel from the accumulators (truncate toward zero)
    // ---------------------------------------------------------------
    logic                  line_active;
    logic [COORD_BITS-1:0] trunc_x;
    logic [COORD_BITS-1:0] trunc_y;

    assign line_active = (pixels_left_reg != '0);

    // floor, then bump negative values that carry a fraction
    assign trunc_x = x_accum_reg[ACC_W-1:FRAC_BITS]
                   + COORD_BITS'(x_accum_reg[ACC_W-1] && (|x_accum_reg[FRAC_BITS-1:0]));
    assign trunc_y = y_accum_reg[ACC_W-1:FRAC_BITS]
                   + COORD_BITS'(y_accum_reg[ACC_W-1] && (|y_accum_reg[FRAC_BITS-1:0]));

    always_comb
    begin
        x_accum_next     = x_accum_reg;
        y_accum_next     = y_accum_reg;
        x_inc_next       = x_inc_reg;
        y_inc_next       = y_inc_reg;
        pixels_left_next = pixels_left_reg;
        mag_y_next       = mag_y_reg;
        x_neg_next       = x_neg_reg;
        y_neg_next       = y_neg_reg;

        if (accept_start)
        begin
            x_accum_next     = {x_start, {FRAC_BITS{1'b0}}};
            y_accum_next     = {y_start, {FRAC_BITS{1'b0}}};
            x_inc_next       = '0;
            y_inc_next       = '0;
            pixels_left_next = steps;
            mag_y_next       = mag_y;
            x_neg_next       = dx[COORD_BITS];
            y_neg_next       = dy[COORD_BITS];
        end
        else if (accept_step && line_active)
        begin
            x_accum_next     = x_accum_reg + {{(ACC_W-INC_W){x_inc_reg[INC_W-1]}}, x_inc_reg};
            y_accum_next     = y_accum_reg + {{(ACC_W-INC_W){y_inc_reg[INC_W-1]}}, y_inc_reg};
            pixels_left_next = pixels_left_reg - COORD_BITS'(1);
        end

        if (ctrl.load_inc_x)
            x_inc_next = x_neg_reg ? quot_neg : quot_pos;
        if (ctrl.load_inc_y)
            y_inc_next = y_neg_reg ? quot_neg : quot_pos;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_accum_reg     <= '0;
            y_accum_reg     <= '0;
            x_inc_reg       <= '0;
            y_inc_reg       <= '0;
            pixels_left_reg <= '0;
        end
        else
        begin
            x_accum_reg     <= x_accum_next;
            y_accum_reg     <= y_accum_next;
            x_inc_reg       <= x_inc_next;
            y_inc_reg       <= y_inc_next;
            pixels_left_reg <= pixels_left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_y_reg <= mag_y_next;
        x_neg_reg <= x_neg_next;
        y_neg_reg <= y_neg_next;
    end

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    logic                  out_valid_reg,   out_valid_next;
    logic                  pixel_valid_reg, pixel_valid_next;
    logic [COORD_BITS-1:0] pixel_x_reg,     pixel_x_next;
    logic [COORD_BITS-1:0] pixel_y_reg,     pixel_y_next;
    logic                  last_pixel_reg,  last_pixel_next;

    always_comb
    begin
        out_valid_next   = out_valid_reg && !out_ready;
        pixel_valid_next = pixel_valid_reg;
        pixel_x_next     = pixel_x_reg;
        pixel_y_next     = pixel_y_reg;
        last_pixel_next  = last_pixel_reg;

        if (accept_step)
        begin
            out_valid_next   = 1'b1;
            pixel_valid_next = line_active;
            pixel_x_next     = line_active ? trunc_x : '0;
            pixel_y_next     = line_active ? trunc_y : '0;
            last_pixel_next  = (pixels_left_reg == COORD_BITS'(1));
        end
        else if ((accept_start && steps_zero) || ctrl.push_start)
        begin
            // start results carry no pixel
            out_valid_next   = 1'b1;
            pixel_valid_next = 1'b0;
            pixel_x_next     = '0;
            pixel_y_next     = '0;
            last_pixel_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        pixel_valid_reg <= pixel_valid_next;
        pixel_x_reg     <= pixel_x_next;
        pixel_y_reg     <= pixel_y_next;
        last_pixel_reg  <= last_pixel_next;
    end

    // idle sequencer and a free (or draining) output register
    assign in_ready    = !ctrl.busy && (!out_valid_reg || out_ready);
    assign out_valid   = out_valid_reg;
    assign pixel_valid = pixel_valid_reg;
    assign pixel_x     = pixel_x_reg;
    assign pixel_y     = pixel_y_reg;
    assign last_pixel  = last_pixel_reg;

endmodule

`default_nettype wire

### rtl/dlr_divider.sv
// Serial restoring divider: (dividend << FRAC_BITS) / divisor, one quotient bit per cycle.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
`default_nettype none

module dlr_divider #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [COORD_BITS-1:0] dividend,
    input  wire logic [COORD_BITS-1:0] divisor,
    output logic      [FRAC_BITS:0]    quotient,
    output logic                       done
);

    localparam int W     = COORD_BITS + FRAC_BITS;
    localparam int CNT_W = $clog2(W + 1);

    logic [W-1:0]          work_reg,    work_next;
    logic [COORD_BITS-1:0] rem_reg,     rem_next;
    logic [COORD_BITS-1:0] divisor_reg, divisor_next;
    logic [CNT_W-1:0]      cnt_reg,     cnt_next;
    logic                  done_reg,    done_next;

    logic [COORD_BITS:0] trial;
    logic [COORD_BITS:0] diff;
    logic                fits;

    assign trial = {rem_reg, work_reg[W-1]};
    assign diff  = trial - {1'b0, divisor_reg};
    assign fits  = ~diff[COORD_BITS];

    always_comb
    begin
        work_next    = work_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        cnt_next     = cnt_reg;
        done_next    = 1'b0;
        if (start)
        begin
            work_next    = {dividend, {FRAC_BITS{1'b0}}};
            rem_next     = '0;
            divisor_next = divisor;
            cnt_next     = CNT_W'(W);
        end
        else if (cnt_reg != '0)
        begin
            // quotient bits shift in where dividend bits leave
            work_next = {work_reg[W-2:0], fits};
            rem_next  = fits ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
            cnt_next  = cnt_reg - CNT_W'(1);
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg    <= work_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
    end

    // result never exceeds 1.0, so FRAC_BITS+1 bits hold it
    assign quotient = work_reg[FRAC_BITS:0];
    assign done     = done_reg;

endmodule

`default_nettype wire

### rtl/dlr_ctrl.sv
// Sequencer for line set-up: runs the shared divider for x, then for y.
// Depends on dlr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dlr_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start_line,
    input  wire logic            div_done,
    output dlr_pkg::dlr_ctrl_t   ctrl
);

    dlr_pkg::dlr_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dlr_pkg::ST_IDLE:  if (start_line) state_next = dlr_pkg::ST_DIV_X;
            dlr_pkg::ST_DIV_X: if (div_done)   state_next = dlr_pkg::ST_DIV_Y;
            dlr_pkg::ST_DIV_Y: if (div_done)   state_next = dlr_pkg::ST_IDLE;
            default:                           state_next = dlr_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl = '0;
        unique case (state_reg)
            dlr_pkg::ST_IDLE:
            begin
                ctrl.div_start = start_line;
            end
            dlr_pkg::ST_DIV_X:
            begin
                ctrl.busy       = 1'b1;
                ctrl.div_sel_y  = 1'b1;
                ctrl.div_start  = div_done;
                ctrl.load_inc_x = div_done;
            end
            dlr_pkg::ST_DIV_Y:
            begin
                ctrl.busy       = 1'b1;
                ctrl.load_inc_y = div_done;
                ctrl.push_start = div_done;
            end
            default:
            begin
                ctrl.busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= dlr_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

### rtl/dlr_checker.sv
// Port-level checks for dda_line_rasterizer_unit, attached by bind.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module dlr_checker #(
    parameter int COORD_BITS = 12
) (
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  in_valid,
    input wire logic                  in_ready,
    input wire logic                  opcode,
    input wire logic                  out_valid,
    input wire logic                  out_ready,
    input wire logic                  pixel_valid,
    input wire logic [COORD_BITS-1:0] pixel_x,
    input wire logic [COORD_BITS-1:0] pixel_y,
    input wire logic                  last_pixel
);

    // a step request answers on the very next cycle
    a_step_answers: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && opcode |=> out_valid)
        else $error("step request gave no result next cycle");

    // a start never produces a pixel
    a_start_no_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !opcode |=> !(out_valid && pixel_valid))
        else $error("start request produced a pixel");

    // empty results are all zero
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !pixel_valid |-> pixel_x == '0 && pixel_y == '0 && !last_pixel)
        else $error("empty result carries nonzero fields");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before it was taken");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(pixel_x) && $stable(pixel_y)
                                    && $stable(pixel_valid) && $stable(last_pixel))
        else $error("stalled result changed");

endmodule

bind dda_line_rasterizer_unit dlr_checker #(
    .COORD_BITS (COORD_BITS)
) u_dlr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .opcode      (opcode),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pixel_valid (pixel_valid),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .last_pixel  (last_pixel)
);

`default_nettype wire
